/* rtl/bfcl_pkg.sv */
// ----------------------------------------------------------------------------
// bfcl_pkg: shared types and constants of the clamped box filter
// Field widths, register codes, state encodings and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bfcl_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned LEN_REG_W  = 13;
  localparam int unsigned RAD_REG_W  = 6;
  localparam int unsigned SPAN_W     = RAD_REG_W + 1;
  localparam int unsigned SUM_W      = SAMPLE_W + SPAN_W;
  localparam int unsigned RING_DEPTH = 128;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

  // reciprocal of the window width: m = ceil(2^RECIP_K / (2r+1))
  localparam int unsigned RECIP_K     = SUM_W + SPAN_W;
  localparam int unsigned RECIP_W     = RECIP_K - 1;
  localparam int unsigned RECIP_CNT_W = $clog2(RECIP_K);
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned DEF_MAX_LINE    = 4096;
  localparam int unsigned DEF_MAX_RADIUS  = 63;
  localparam int unsigned DEF_SAMPLE_BITS = 16;

  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned CFG_IDX_LSB = 2;

  localparam logic [LEN_REG_W-1:0] LEN_RESET = 13'd1920;
  localparam logic [RAD_REG_W-1:0] RAD_RESET = 6'd1;

  typedef enum logic [0:0] {
    REG_LINE_LENGTH = 1'b0,
    REG_BOX_RADIUS  = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ISS_STREAM = 1'b0,
    ISS_DRAIN  = 1'b1
  } iss_state_e;

  typedef enum logic [0:0] {
    RC_IDLE = 1'b0,
    RC_RUN  = 1'b1
  } rc_state_e;

  typedef struct packed {
    logic               busy;
    logic [RECIP_W-1:0] m;
  } recip_t;

  typedef struct packed {
    logic valid;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

/* rtl/bfcl_ram.sv */
// ----------------------------------------------------------------------------
// bfcl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfcl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/bfcl_fifo.sv */
// ----------------------------------------------------------------------------
// bfcl_fifo: short queue between front end and back end
// Register FIFO of classified samples; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfcl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire logic [WIDTH-1:0]       data_i,
  input  wire logic                   pop_i,
  output logic      [WIDTH-1:0]       data_o,
  output bfcl_pkg::fifo_stat_t        stat_o
);

  import bfcl_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  assign data_o       = slot_q[rptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == CW'(DEPTH));

endmodule

`default_nettype wire

/* rtl/bfcl_front.sv */
// ----------------------------------------------------------------------------
// bfcl_front: input side of the clamped box filter
// Accepts samples, numbers them within the line and flags the line end.
// ----------------------------------------------------------------------------
`default_nettype none

module bfcl_front #(
  parameter int unsigned MAX_LINE    = bfcl_pkg::DEF_MAX_LINE,
  parameter int unsigned SAMPLE_BITS = bfcl_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [bfcl_pkg::SAMPLE_W-1:0]        sample_i,
  input  wire logic                                 line_end_i,
  input  wire logic [bfcl_pkg::LEN_REG_W-1:0]       len_reg_i,
  input  wire logic                                 clear_i,
  input  wire logic                                 hold_i,
  input  wire logic                                 fifo_full_i,
  output logic                                      push_o,
  output logic [bfcl_pkg::SAMPLE_W+$clog2(MAX_LINE):0] entry_o
);

  import bfcl_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_LINE);
  localparam int unsigned CMP_W = (IDX_W + 1 > LEN_REG_W) ? IDX_W + 1 : LEN_REG_W;
  localparam logic [SAMPLE_W-1:0] SampleMask =
    (SAMPLE_BITS >= SAMPLE_W) ? '1 : SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [IDX_W-1:0] in_count_q, in_count_d;
  logic [CMP_W-1:0] len_ext, len_eff, next_cnt;
  logic             accept, ends;

  always_comb begin
    len_ext = CMP_W'(len_reg_i);
    if (len_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_ext > CMP_W'(MAX_LINE)) begin
      len_eff = CMP_W'(MAX_LINE);
    end else begin
      len_eff = len_ext;
    end
    next_cnt = CMP_W'(in_count_q) + CMP_W'(1);
    ends     = line_end_i || (next_cnt >= len_eff);
  end

  assign in_stall_o = fifo_full_i || hold_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_count_d = in_count_q;
    if (clear_i) begin
      in_count_d = '0;
    end else if (accept) begin
      in_count_d = ends ? '0 : in_count_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q <= '0;
    end else begin
      in_count_q <= in_count_d;
    end
  end

  assign push_o  = accept;
  assign entry_o = {sample_i & SampleMask, in_count_q, ends};

endmodule

`default_nettype wire

/* rtl/bfcl_recip.sv */
// ----------------------------------------------------------------------------
// bfcl_recip: window reciprocal unit
// Restoring divider, one quotient bit per cycle, giving ceil(2^K / (2r+1)).
// ----------------------------------------------------------------------------
`default_nettype none

module bfcl_recip (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [bfcl_pkg::RAD_REG_W-1:0] r_i,
  output bfcl_pkg::recip_t                    recip_o
);

  import bfcl_pkg::*;

  rc_state_e              state_q, state_d;
  logic [RECIP_CNT_W-1:0] cnt_q, cnt_d;
  logic [SPAN_W-1:0]      rem_q, rem_d;
  logic [RECIP_K-1:0]     quo_q, quo_d;
  logic [RECIP_W-1:0]     m_q;
  logic [SPAN_W-1:0]      width;
  logic [SPAN_W:0]        trial;
  logic                   ge;
  logic [SPAN_W-1:0]      rem_next;
  logic [RECIP_K-1:0]     quo_next;
  logic                   last;

  assign width    = {r_i, 1'b1};
  assign trial    = {rem_q, 1'b1};
  assign ge       = trial >= {1'b0, width};
  assign rem_next = ge ? SPAN_W'(trial - {1'b0, width}) : SPAN_W'(trial);
  assign quo_next = {quo_q[RECIP_K-2:0], ge};
  assign last     = (cnt_q == RECIP_CNT_W'(RECIP_K - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      RC_IDLE: if (start_i) state_d = RC_RUN;
      RC_RUN:  if (!start_i && last) state_d = RC_IDLE;
      default: state_d = RC_RUN;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = '0;
      rem_d = '0;
      quo_d = '0;
    end else if (state_q == RC_RUN) begin
      cnt_d = cnt_q + RECIP_CNT_W'(1);
      rem_d = rem_next;
      quo_d = quo_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RC_RUN;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == RC_RUN && last && !start_i) begin
      m_q <= RECIP_W'(quo_next + RECIP_K'(1));
    end
  end

  assign recip_o.busy = (state_q == RC_RUN);
  assign recip_o.m    = m_q;

endmodule

`default_nettype wire

/* rtl/bfcl_back.sv */
// ----------------------------------------------------------------------------
// bfcl_back: execution side of the clamped box filter
// Issues stream and drain steps, keeps the running sum and window ring,
// divides by the window width through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module bfcl_back #(
  parameter int unsigned MAX_LINE = bfcl_pkg::DEF_MAX_LINE
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic [bfcl_pkg::SAMPLE_W+$clog2(MAX_LINE):0] entry_i,
  input  bfcl_pkg::fifo_stat_t                         fifo_stat_i,
  output logic                                         pop_o,
  input  wire logic [bfcl_pkg::RAD_REG_W-1:0]          r_i,
  input  bfcl_pkg::recip_t                             recip_i,
  input  wire logic                                    out_stall_i,
  output logic                                         out_valid_o,
  output logic [bfcl_pkg::SAMPLE_W-1:0]                filtered_o,
  output logic [bfcl_pkg::POS_W-1:0]                   position_o,
  output logic                                         run_last_o,
  output logic                                         line_done_o
);

  import bfcl_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_LINE);
  localparam int unsigned JW    = $clog2(MAX_LINE + RING_DEPTH);

  logic [SAMPLE_W-1:0] e_sample;
  logic [IDX_W-1:0]    e_idx;
  logic                e_ends;

  assign {e_sample, e_idx, e_ends} = entry_i;

  logic              en;
  logic [SPAN_W-1:0] span;
  logic              out_valid_q;

  assign en   = !out_valid_q || !out_stall_i;
  assign span = {r_i, 1'b1};

  // issue sequencer
  iss_state_e           state_q, state_d;
  logic [JW-1:0]        drain_j_q, drain_j_d;
  logic [RAD_REG_W-1:0] drain_cnt_q, drain_cnt_d;
  logic [SAMPLE_W-1:0]  last_q, last_d;

  logic                iss_valid, iss_main, iss_first, iss_ends, iss_last_drain;
  logic [JW-1:0]       iss_j;
  logic [SAMPLE_W-1:0] iss_add;
  logic                iss_fire, iss_emit, iss_use_ring, iss_run_last;
  logic [POS_W-1:0]    iss_pos;

  always_comb begin
    iss_valid      = 1'b0;
    iss_main       = 1'b0;
    iss_first      = 1'b0;
    iss_ends       = 1'b0;
    iss_last_drain = 1'b0;
    iss_j          = drain_j_q;
    iss_add        = last_q;
    case (state_q)
      ISS_STREAM: begin
        iss_valid = fifo_stat_i.valid;
        iss_main  = 1'b1;
        iss_j     = JW'(e_idx);
        iss_add   = e_sample;
        iss_first = (e_idx == '0);
        iss_ends  = e_ends;
      end
      ISS_DRAIN: begin
        iss_valid      = 1'b1;
        iss_last_drain = (drain_cnt_q == RAD_REG_W'(1));
      end
      default: ;
    endcase
  end

  assign iss_fire     = en && iss_valid;
  assign pop_o        = iss_fire && iss_main;
  assign iss_emit     = iss_j >= JW'(r_i);
  assign iss_use_ring = iss_j >= JW'(span);
  assign iss_pos      = POS_W'(iss_j - JW'(r_i));
  assign iss_run_last = (iss_main && !iss_ends) || iss_last_drain;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ISS_STREAM: if (iss_fire && iss_ends) state_d = ISS_DRAIN;
      ISS_DRAIN:  if (iss_fire && iss_last_drain) state_d = ISS_STREAM;
      default:    state_d = ISS_STREAM;
    endcase
  end

  always_comb begin
    drain_j_d   = drain_j_q;
    drain_cnt_d = drain_cnt_q;
    last_d      = last_q;
    if (iss_fire) begin
      if (iss_main) begin
        drain_j_d   = iss_j + JW'(1);
        drain_cnt_d = r_i;
        last_d      = e_sample;
      end else begin
        drain_j_d   = drain_j_q + JW'(1);
        drain_cnt_d = drain_cnt_q - RAD_REG_W'(1);
      end
    end
  end

  // window ring
  logic [SAMPLE_W-1:0] ring_rdata;

  bfcl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (iss_fire && iss_main),
    .waddr_i (iss_j[RING_AW-1:0]),
    .wdata_i (iss_add),
    .re_i    (iss_fire),
    .raddr_i (RING_AW'(iss_j - JW'(span))),
    .rdata_o (ring_rdata)
  );

  // sum stage
  logic                a_valid_q, a_first_q, a_use_ring_q, a_emit_q;
  logic                a_run_last_q, a_line_done_q;
  logic [SAMPLE_W-1:0] a_add_q;
  logic [POS_W-1:0]    a_pos_q;
  logic [SAMPLE_W-1:0] first_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] leaving;

  assign leaving = a_use_ring_q ? ring_rdata : first_q;

  always_comb begin
    if (a_first_q) begin
      sum_d = SUM_W'(span) * SUM_W'(a_add_q);
    end else begin
      sum_d = sum_q - SUM_W'(leaving) + SUM_W'(a_add_q);
    end
  end

  // divide stage
  logic                b_valid_q, b_run_last_q, b_line_done_q;
  logic [POS_W-1:0]    b_pos_q;
  logic [SUM_W-1:0]    dividend;
  logic [PROD_W-1:0]   prod;

  assign dividend = sum_q + SUM_W'(r_i);
  assign prod     = PROD_W'(dividend) * PROD_W'(recip_i.m);

  // output register
  logic [SAMPLE_W-1:0] filtered_q;
  logic [POS_W-1:0]    position_q;
  logic                run_last_q, line_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ISS_STREAM;
      drain_j_q   <= '0;
      drain_cnt_q <= '0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      first_q     <= '0;
    end else begin
      state_q     <= state_d;
      drain_j_q   <= drain_j_d;
      drain_cnt_q <= drain_cnt_d;
      if (en) begin
        a_valid_q   <= iss_fire;
        b_valid_q   <= a_valid_q && a_emit_q;
        out_valid_q <= b_valid_q;
        if (a_valid_q) begin
          sum_q <= sum_d;
          if (a_first_q) begin
            first_q <= a_add_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    if (en) begin
      a_first_q     <= iss_first;
      a_use_ring_q  <= iss_use_ring;
      a_emit_q      <= iss_emit;
      a_add_q       <= iss_add;
      a_pos_q       <= iss_pos;
      a_run_last_q  <= iss_run_last;
      a_line_done_q <= iss_last_drain;
      b_pos_q       <= a_pos_q;
      b_run_last_q  <= a_run_last_q;
      b_line_done_q <= a_line_done_q;
      filtered_q    <= prod[RECIP_K +: SAMPLE_W];
      position_q    <= b_pos_q;
      run_last_q    <= b_run_last_q;
      line_done_q   <= b_line_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign position_o  = position_q;
  assign run_last_o  = run_last_q;
  assign line_done_o = line_done_q;

endmodule

`default_nettype wire

/* rtl/box_filter_clamped_line_core.sv */
// ----------------------------------------------------------------------------
// box_filter_clamped_line_core: streaming clamp-to-edge box filter, one line
// Throughput: one sample per cycle unless input or output stalls; a line end
// adds r drain steps, since stream and drain steps share the single issue
// slot of the back end. Reset: registers return to line length 1920, window
// radius 1; input stalls after reset and after each radius write while the
// reciprocal divider runs.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_clamped_line_core #(
  parameter int unsigned MAX_LINE    = bfcl_pkg::DEF_MAX_LINE,
  parameter int unsigned MAX_RADIUS  = bfcl_pkg::DEF_MAX_RADIUS,
  parameter int unsigned SAMPLE_BITS = bfcl_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bfcl_pkg::APB_AW-1:0]   paddr,
  input  wire logic [bfcl_pkg::APB_DW-1:0]   pwdata,
  output logic      [bfcl_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bfcl_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                          line_end_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [bfcl_pkg::SAMPLE_W-1:0] filtered_o,
  output logic      [bfcl_pkg::POS_W-1:0]    position_o,
  output logic                               run_last_o,
  output logic                               line_done_o
);

  import bfcl_pkg::*;

  localparam int unsigned ENTRY_W = SAMPLE_W + $clog2(MAX_LINE) + 1;

  // configuration registers
  logic [LEN_REG_W-1:0] len_q, len_d;
  logic [RAD_REG_W-1:0] rad_q, rad_d;
  logic [RAD_REG_W-1:0] r_eff;
  logic                 cfg_wr, rad_wr;
  cfg_reg_e             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_e'(paddr[CFG_IDX_LSB]);

  always_comb begin
    len_d  = len_q;
    rad_d  = rad_q;
    rad_wr = 1'b0;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_LINE_LENGTH: len_d = pwdata[LEN_REG_W-1:0];
        REG_BOX_RADIUS: begin
          rad_d  = pwdata[RAD_REG_W-1:0];
          rad_wr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LINE_LENGTH: prdata = APB_DW'(len_q);
      REG_BOX_RADIUS:  prdata = APB_DW'(rad_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
      rad_q <= RAD_RESET;
    end else begin
      len_q <= len_d;
      rad_q <= rad_d;
    end
  end

  always_comb begin
    if (rad_q == '0) begin
      r_eff = RAD_REG_W'(1);
    end else if (rad_q > RAD_REG_W'(MAX_RADIUS)) begin
      r_eff = RAD_REG_W'(MAX_RADIUS);
    end else begin
      r_eff = rad_q;
    end
  end

  // datapath
  recip_t             recip_st;
  fifo_stat_t         fifo_stat;
  logic               push, pop;
  logic [ENTRY_W-1:0] push_entry, head_entry;

  bfcl_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rad_wr),
    .r_i     (r_eff),
    .recip_o (recip_st)
  );

  bfcl_front #(
    .MAX_LINE    (MAX_LINE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .line_end_i  (line_end_i),
    .len_reg_i   (len_q),
    .clear_i     (cfg_wr),
    .hold_i      (recip_st.busy),
    .fifo_full_i (fifo_stat.full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  bfcl_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .pop_i  (pop),
    .data_o (head_entry),
    .stat_o (fifo_stat)
  );

  bfcl_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .r_i         (r_eff),
    .recip_i     (recip_st),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .filtered_o  (filtered_o),
    .position_o  (position_o),
    .run_last_o  (run_last_o),
    .line_done_o (line_done_o)
  );

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    recip_st.busy |-> in_stall_o)
    else $error("input taken while reciprocal is being computed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (cfg_idx == REG_BOX_RADIUS) |=> recip_st.busy)
    else $error("radius write did not restart reciprocal unit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> run_last_o)
    else $error("line end result not marked as last of its step");
`endif

endmodule

`default_nettype wire
